### sv/htfd_pkg.sv
package htfd_pkg;

  localparam int unsigned FIFO_DEPTH = 2;

  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_POLY = 8'h31;

  // conversion constants
  localparam logic [14:0] TEMP_SCALE  = 15'd17500;
  localparam logic [13:0] HUM_SCALE   = 14'd12500;
  localparam logic [15:0] FULL_SCALE  = 16'd65535;
  localparam logic [15:0] TEMP_OFFSET = 16'd4500;
  localparam logic [13:0] HUM_OFFSET  = 14'd600;
  localparam logic [13:0] HUM_MAX     = 14'd10000;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_TEMP_CRC = 2'd1,
    STATUS_HUM_CRC  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    POS_T_MSB = 3'd0,
    POS_T_LSB = 3'd1,
    POS_T_CRC = 3'd2,
    POS_H_MSB = 3'd3,
    POS_H_LSB = 3'd4,
    POS_H_CRC = 3'd5
  } pos_e;

  typedef struct packed {
    status_e     status;
    logic [15:0] temp_word;
    logic [15:0] humid_word;
  } frame_rec_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

  // floor(x / 65535) for x below 2^31: estimate x>>16, remainder stays under 2*65535
  function automatic logic [14:0] div_full_scale(input logic [30:0] x);
    logic [14:0] q0;
    logic [16:0] r;
    q0 = x[30:16];
    r  = {1'b0, x[15:0]} + {2'b00, q0};
    return q0 + ((r >= {1'b0, FULL_SCALE}) ? 15'd1 : 15'd0);
  endfunction

endpackage

### sv/htfd_front.sv
module htfd_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  logic [7:0]           data_byte_i,
  input  logic                 frame_start_i,
  output logic                 push_o,
  output htfd_pkg::frame_rec_t rec_o
);

  htfd_pkg::pos_e  pos_q, pos_d, pos_cur;
  logic [7:0]      crc_q, crc_d;
  logic [15:0]     tword_q, tword_d;
  logic [15:0]     hword_q, hword_d;
  logic            tfail_q, tfail_d;

  always_comb begin
    pos_cur = frame_start_i ? htfd_pkg::POS_T_MSB : pos_q;
    pos_d   = pos_q;
    crc_d   = crc_q;
    tword_d = tword_q;
    hword_d = hword_q;
    tfail_d = tfail_q;
    if (accept_i) begin
      case (pos_cur)
        htfd_pkg::POS_T_LSB: begin
          crc_d   = htfd_pkg::crc8_byte(crc_q, data_byte_i);
          tword_d = {tword_q[15:8], data_byte_i};
          pos_d   = htfd_pkg::POS_T_CRC;
        end
        htfd_pkg::POS_T_CRC: begin
          tfail_d = (crc_q != data_byte_i);
          crc_d   = htfd_pkg::CRC_INIT;
          pos_d   = htfd_pkg::POS_H_MSB;
        end
        htfd_pkg::POS_H_MSB: begin
          crc_d   = htfd_pkg::crc8_byte(htfd_pkg::CRC_INIT, data_byte_i);
          hword_d = {data_byte_i, 8'h00};
          pos_d   = htfd_pkg::POS_H_LSB;
        end
        htfd_pkg::POS_H_LSB: begin
          crc_d   = htfd_pkg::crc8_byte(crc_q, data_byte_i);
          hword_d = {hword_q[15:8], data_byte_i};
          pos_d   = htfd_pkg::POS_H_CRC;
        end
        htfd_pkg::POS_H_CRC: begin
          crc_d  = htfd_pkg::CRC_INIT;
          pos_d  = htfd_pkg::POS_T_MSB;
        end
        default: begin
          // byte 0, also taken for unused positions
          crc_d   = htfd_pkg::crc8_byte(htfd_pkg::CRC_INIT, data_byte_i);
          tword_d = {data_byte_i, 8'h00};
          pos_d   = htfd_pkg::POS_T_LSB;
        end
      endcase
    end
  end

  always_comb begin
    push_o           = accept_i && (pos_cur == htfd_pkg::POS_H_CRC);
    rec_o.temp_word  = tword_q;
    rec_o.humid_word = hword_q;
    if (tfail_q) begin
      rec_o.status = htfd_pkg::STATUS_TEMP_CRC;
    end else if (crc_q != data_byte_i) begin
      rec_o.status = htfd_pkg::STATUS_HUM_CRC;
    end else begin
      rec_o.status = htfd_pkg::STATUS_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= htfd_pkg::POS_T_MSB;
      crc_q   <= htfd_pkg::CRC_INIT;
      tword_q <= '0;
      hword_q <= '0;
      tfail_q <= 1'b0;
    end else begin
      pos_q   <= pos_d;
      crc_q   <= crc_d;
      tword_q <= tword_d;
      hword_q <= hword_d;
      tfail_q <= tfail_d;
    end
  end

endmodule

### sv/htfd_fifo.sv
module htfd_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  htfd_pkg::frame_rec_t push_data_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output htfd_pkg::frame_rec_t pop_data_o,
  output logic                 empty_o
);

  localparam int unsigned PtrW = (htfd_pkg::FIFO_DEPTH > 1) ? $clog2(htfd_pkg::FIFO_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(htfd_pkg::FIFO_DEPTH + 1);

  htfd_pkg::frame_rec_t mem_q [htfd_pkg::FIFO_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  assign full_o     = (cnt_q == CntW'(htfd_pkg::FIFO_DEPTH));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(htfd_pkg::FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(htfd_pkg::FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

### sv/htfd_back.sv
module htfd_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 empty_i,
  input  htfd_pkg::frame_rec_t rec_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [1:0]           status_o,
  output logic signed [14:0]   temp_centi_o,
  output logic [13:0]          humid_centi_o,
  output logic [15:0]          temp_raw_word_o,
  output logic [15:0]          humid_raw_word_o
);

  logic                 advance;
  logic                 s1_valid_q;
  htfd_pkg::frame_rec_t s1_rec_q;
  logic [30:0]          s1_tprod_q;
  logic [29:0]          s1_hprod_q;

  logic [14:0]          tq;
  logic [14:0]          hq;
  logic [15:0]          tdiff;
  logic [13:0]          hval;

  logic                 out_valid_q;
  logic [1:0]           status_q;
  logic [14:0]          temp_q;
  logic [13:0]          humid_q;
  logic [15:0]          traw_q, hraw_q;

  // whole pipeline moves unless a finished result is held
  assign advance = !out_valid_q || !out_stall_i;
  assign pop_o   = advance && !empty_i;

  assign tq    = htfd_pkg::div_full_scale(s1_tprod_q);
  assign hq    = htfd_pkg::div_full_scale({1'b0, s1_hprod_q});
  assign tdiff = {1'b0, tq} - htfd_pkg::TEMP_OFFSET;

  always_comb begin
    if (hq < {1'b0, htfd_pkg::HUM_OFFSET}) begin
      hval = '0;
    end else if (hq - {1'b0, htfd_pkg::HUM_OFFSET} > {1'b0, htfd_pkg::HUM_MAX}) begin
      hval = htfd_pkg::HUM_MAX;
    end else begin
      hval = hq[13:0] - htfd_pkg::HUM_OFFSET;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_rec_q   <= rec_i;
      s1_tprod_q <= 31'(htfd_pkg::TEMP_SCALE) * 31'(rec_i.temp_word);
      s1_hprod_q <= 30'(htfd_pkg::HUM_SCALE) * 30'(rec_i.humid_word);
      status_q   <= s1_rec_q.status;
      temp_q     <= tdiff[14:0];
      humid_q    <= hval;
      traw_q     <= s1_rec_q.temp_word;
      hraw_q     <= s1_rec_q.humid_word;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q  <= pop_o;
      out_valid_q <= s1_valid_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign temp_centi_o     = $signed(temp_q);
  assign humid_centi_o    = humid_q;
  assign temp_raw_word_o  = traw_q;
  assign humid_raw_word_o = hraw_q;

`ifndef SYNTHESIS
  a_humid_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> humid_centi_o <= htfd_pkg::HUM_MAX)
    else $error("humidity above full scale");

  a_temp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (temp_centi_o >= -15'sd4500 && temp_centi_o <= 15'sd13000))
    else $error("temperature out of range");

  a_stage_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && advance) |=> out_valid_o)
    else $error("pipeline dropped a transaction");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> !empty_i)
    else $error("pop from empty queue");
`endif

endmodule

### sv/humidity_temp_frame_decoder.sv
// channel | valid      | stall       | payload
// in      | in_valid_i | in_stall_o  | data_byte_i, frame_start_i
// out     | out_valid_o| out_stall_i | status_o, temp_centi_o, humid_centi_o,
//         |            |             | temp_raw_word_o, humid_raw_word_o
//
// one byte per cycle while in_stall_o is low; the crc update is one byte-wide step in the front
// out_valid_o rises once the frame completed at the edge that takes the sixth byte has moved through
// (queue write at that edge, then multiply, then divide and clamp)
// reset clears position, crc and all valid flags; no clearing pass
// in_stall_o rises only while the two-entry frame queue is full
// out_stall_i holds the output register and the conversion pipeline
module humidity_temp_frame_decoder (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         data_byte_i,
  input  logic               frame_start_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         status_o,
  output logic signed [14:0] temp_centi_o,
  output logic [13:0]        humid_centi_o,
  output logic [15:0]        temp_raw_word_o,
  output logic [15:0]        humid_raw_word_o
);

  logic                 accept;
  logic                 push;
  logic                 full;
  logic                 pop;
  logic                 empty;
  htfd_pkg::frame_rec_t push_rec;
  htfd_pkg::frame_rec_t pop_rec;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  htfd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .data_byte_i   (data_byte_i),
    .frame_start_i (frame_start_i),
    .push_o        (push),
    .rec_o         (push_rec)
  );

  htfd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_rec),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_rec),
    .empty_o     (empty)
  );

  htfd_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .empty_i          (empty),
    .rec_i            (pop_rec),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .temp_centi_o     (temp_centi_o),
    .humid_centi_o    (humid_centi_o),
    .temp_raw_word_o  (temp_raw_word_o),
    .humid_raw_word_o (humid_raw_word_o)
  );

endmodule
